FILE: hw/rtl/pht_pkg.sv
`timescale 1ns / 1ps

package pht_pkg;

    localparam int COLOR_W = 12;
    localparam int SHIFT_W = 8;
    localparam int CH_W    = 3;
    localparam int HUE_W   = 16;

    // restoring steps after the first quotient bit
    localparam int DIV_STEPS = HUE_W - 1;

    localparam logic [HUE_W-1:0] HUE_SIXTH   = 16'h2aaa;
    localparam logic [HUE_W-1:0] HUE_YELLOW  = 16'h2aaa;
    localparam logic [HUE_W-1:0] HUE_MAGENTA = 16'hd556;
    localparam logic [HUE_W-1:0] HUE_CYAN    = 16'h8000;
    localparam logic [HUE_W-1:0] HUE_GRN_OFS = 16'h5555;
    localparam logic [HUE_W-1:0] HUE_BLU_OFS = 16'haaaa;
    localparam logic [HUE_W-1:0] FULL_SCALE  = 16'hffff;
    localparam logic [HUE_W-1:0] HALF_SCALE  = 16'h7fff;
    // ceil(2^17 / 3), exact divide by three for 16-bit values
    localparam logic [HUE_W-1:0] DIV3_RECIP  = 16'haaab;

    localparam logic [1:0] BR_RED   = 2'd0;
    localparam logic [1:0] BR_GREEN = 2'd1;
    localparam logic [1:0] BR_BLUE  = 2'd2;

    localparam logic [2:0] HEXT_1 = 3'd1;
    localparam logic [2:0] HEXT_2 = 3'd2;
    localparam logic [2:0] HEXT_3 = 3'd3;
    localparam logic [2:0] HEXT_4 = 3'd4;
    localparam logic [2:0] HEXT_5 = 3'd5;

    typedef logic [1:0] pht_branch_t;

    typedef struct packed {
        logic [COLOR_W-1:0] word;
        logic               bypass;
        logic [HUE_W-1:0]   shift16;
        logic [HUE_W-1:0]   mx;
        logic [HUE_W-1:0]   delta;
        logic               sat_full;
        pht_branch_t        branch;
        logic               neg;
        logic               spec;
        logic [HUE_W-1:0]   spec_hue;
        logic [HUE_W:0]     sat_rem;
        logic [HUE_W-1:0]   sat_quo;
        logic [HUE_W:0]     hue_rem;
        logic [HUE_W-1:0]   hue_quo;
        logic [HUE_W-1:0]   hue_part;
        logic [HUE_W-1:0]   sat;
        logic [HUE_W-1:0]   hue;
        logic [2:0]         hext;
        logic [HUE_W-1:0]   remh;
        logic [HUE_W-1:0]   sat_half;
        logic [HUE_W-1:0]   p;
        logic [HUE_W-1:0]   prodq;
        logic [HUE_W-1:0]   prodt;
        logic [HUE_W-1:0]   q;
        logic [HUE_W-1:0]   t;
    } pht_item_t;

    // replicate a 3-bit channel across 16 bits
    function automatic logic [HUE_W-1:0] widen3(input logic [CH_W-1:0] v);
        widen3 = {v, v, v, v, v, v[CH_W-1]};
    endfunction

endpackage

FILE: hw/rtl/pht_if.sv
`timescale 1ns / 1ps

interface pht_req_if;
    import pht_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color_in;
    logic [SHIFT_W-1:0] shift_amount;
    modport source (output valid, output color_in, output shift_amount, input ready);
    modport sink   (input valid, input color_in, input shift_amount, output ready);
endinterface

interface pht_rsp_if;
    import pht_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color_out;
    modport source (output valid, output color_out, input ready);
    modport sink   (input valid, input color_out, output ready);
endinterface

FILE: hw/rtl/palette_hue_rotator.sv
// palette hue rotator: a pipeline of the entry stage, 15 restoring divide stages,
// five arithmetic stages and the output register, one bit of both quotients per
// divide stage
// throughput one word per cycle while the output is not stalled, every stage then takes a new transfer each cycle
// a stalled output backs up stage by stage, empty stages keep filling
// reset clears every stage valid bit and the output valid, datapath is not reset
`timescale 1ns / 1ps

module palette_hue_rotator (
    input  logic       clk,
    input  logic       rst_n,
    pht_req_if.sink    request,
    pht_rsp_if.source  response
);
    import pht_pkg::*;

    // stage map: entry, divide steps, then five arithmetic stages
    localparam int ST_H1 = DIV_STEPS + 1;   // divide by three, saturation
    localparam int ST_H2 = DIV_STEPS + 2;   // branch offset, rotation
    localparam int ST_H3 = DIV_STEPS + 3;   // hextant and remainder
    localparam int ST_H4 = DIV_STEPS + 4;   // p and the two scale products
    localparam int ST_H5 = DIV_STEPS + 5;   // q and t
    localparam int NS    = DIV_STEPS + 6;

    pht_item_t          stage_reg  [NS];
    pht_item_t          stage_next [NS];
    logic [NS-1:0]      valid_reg;
    logic [NS-1:0]      stage_load;
    logic               out_load;
    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic [COLOR_W-1:0] out_color_next;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        out_load = !out_valid_reg || response.ready;
        stage_load[NS-1] = !valid_reg[NS-1] || out_load;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_load[k] = !valid_reg[k] || stage_load[k+1];
        end
    end

    assign request.ready   = stage_load[0];
    assign response.valid  = out_valid_reg;
    assign response.color_out = out_color_reg;

    // entry: widen channels, max/min, branch, bypass and full-scale checks, first quotient bit of both divides
    always_comb
    begin : entry_calc
        logic [CH_W-1:0]  cr;
        logic [CH_W-1:0]  cg;
        logic [CH_W-1:0]  cb;
        logic [HUE_W-1:0] r;
        logic [HUE_W-1:0] g;
        logic [HUE_W-1:0] b;
        logic [HUE_W-1:0] mx;
        logic [HUE_W-1:0] mn;
        logic [HUE_W-1:0] op_a;
        logic [HUE_W-1:0] op_b;
        logic [HUE_W-1:0] mag;
        logic             sat_ge;
        logic             hue_ge;
        pht_item_t        item;

        cr = request.color_in[3:1];
        cg = request.color_in[7:5];
        cb = request.color_in[11:9];
        r  = widen3(cr);
        g  = widen3(cg);
        b  = widen3(cb);

        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;

        item          = '0;
        item.word     = request.color_in;
        item.bypass   = (request.shift_amount == '0) || (cr == cg && cg == cb);
        item.shift16  = {request.shift_amount, request.shift_amount};
        item.mx       = mx;
        item.delta    = mx - mn;
        item.sat_full = (mn == '0);

        // ties go red, then green
        if (r == mx)
        begin
            item.branch = BR_RED;
            op_a = g;
            op_b = b;
        end
        else if (g == mx)
        begin
            item.branch = BR_GREEN;
            op_a = b;
            op_b = r;
        end
        else
        begin
            item.branch = BR_BLUE;
            op_a = r;
            op_b = g;
        end

        // divide magnitudes, truncation toward zero is restored by the sign later
        item.neg = op_a < op_b;
        mag      = item.neg ? (op_b - op_a) : (op_a - op_b);

        // full-scale differences: pure yellow, magenta and cyan
        if (mag == FULL_SCALE)
        begin
            if (item.branch == BR_RED)
            begin
                item.spec     = 1'b1;
                item.spec_hue = item.neg ? HUE_MAGENTA : HUE_YELLOW;
            end
            else if (item.branch == BR_GREEN && !item.neg)
            begin
                item.spec     = 1'b1;
                item.spec_hue = HUE_CYAN;
            end
        end

        sat_ge       = item.delta >= mx;
        item.sat_rem = sat_ge ? {1'b0, item.delta - mx} : {1'b0, item.delta};
        item.sat_quo = {{(HUE_W-1){1'b0}}, sat_ge};
        hue_ge       = mag >= item.delta;
        item.hue_rem = hue_ge ? {1'b0, mag - item.delta} : {1'b0, mag};
        item.hue_quo = {{(HUE_W-1){1'b0}}, hue_ge};

        stage_next[0] = item;
    end

    // restoring divide, one quotient bit per stage for both quotients
    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_div
        logic [HUE_W:0]   sat_rem_next;
        logic [HUE_W-1:0] sat_quo_next;
        logic [HUE_W:0]   hue_rem_next;
        logic [HUE_W-1:0] hue_quo_next;

        pht_div_step u_sat_step (
            .rem      (stage_reg[k-1].sat_rem),
            .den      (stage_reg[k-1].mx),
            .quo      (stage_reg[k-1].sat_quo),
            .rem_next (sat_rem_next),
            .quo_next (sat_quo_next)
        );

        pht_div_step u_hue_step (
            .rem      (stage_reg[k-1].hue_rem),
            .den      (stage_reg[k-1].delta),
            .quo      (stage_reg[k-1].hue_quo),
            .rem_next (hue_rem_next),
            .quo_next (hue_quo_next)
        );

        always_comb
        begin
            stage_next[k]         = stage_reg[k-1];
            stage_next[k].sat_rem = sat_rem_next;
            stage_next[k].sat_quo = sat_quo_next;
            stage_next[k].hue_rem = hue_rem_next;
            stage_next[k].hue_quo = hue_quo_next;
        end
    end

    // back end: hue assembly, hextant split and the p/q/t products
    always_comb
    begin : back_calc
        logic [2*HUE_W-1:0] prod3;
        logic [HUE_W-1:0]   signed_part;
        logic [HUE_W-1:0]   base;
        logic [2:0]         cnt;
        logic [HUE_W-1:0]   rem;
        logic [HUE_W-1:0]   rem6;
        logic [HUE_W-1:0]   remt;
        logic [2*HUE_W-1:0] prod_p;
        logic [2*HUE_W-1:0] prod_q;
        logic [2*HUE_W-1:0] prod_t;
        logic [2*HUE_W-1:0] scl_q;
        logic [2*HUE_W-1:0] scl_t;
        pht_item_t          h1;
        pht_item_t          h2;
        pht_item_t          h3;
        pht_item_t          h4;
        pht_item_t          h5;

        // quotient divided by three through the reciprocal
        h1 = stage_reg[ST_H1-1];
        prod3 = {{HUE_W{1'b0}}, h1.hue_quo} * {{HUE_W{1'b0}}, DIV3_RECIP};
        h1.hue_part = {1'b0, prod3[2*HUE_W-1:HUE_W+1]};
        h1.sat = h1.sat_full ? FULL_SCALE : {h1.sat_quo[HUE_W-2:0], 1'b0};
        stage_next[ST_H1] = h1;

        // branch offset and rotation, modulo 2^16
        h2 = stage_reg[ST_H2-1];
        signed_part = h2.neg ? (~h2.hue_part + 16'd1) : h2.hue_part;
        case (h2.branch)
            BR_RED:   base = signed_part;
            BR_GREEN: base = signed_part + HUE_GRN_OFS;
            default:  base = signed_part + HUE_BLU_OFS;
        endcase
        if (h2.spec)
        begin
            base = h2.spec_hue;
        end
        h2.hue = base + h2.shift16;
        stage_next[ST_H2] = h2;

        // hextant by compare against multiples of one sixth
        h3 = stage_reg[ST_H3-1];
        cnt = '0;
        for (int j = 1; j <= 6; j++)
        begin
            if ({{HUE_W{1'b0}}, h3.hue} >= (2*HUE_W)'(j * int'(HUE_SIXTH)))
            begin
                cnt = cnt + 3'd1;
            end
        end
        h3.hext = cnt;
        rem  = h3.hue - HUE_W'({{(HUE_W-3){1'b0}}, cnt} * {{3{1'b0}}, HUE_SIXTH});
        rem6 = HUE_W'({rem, 2'b00} + {1'b0, rem, 1'b0});
        h3.remh     = {1'b0, rem6[HUE_W-1:1]};
        h3.sat_half = {1'b0, h3.sat[HUE_W-1:1]};
        stage_next[ST_H3] = h3;

        h4 = stage_reg[ST_H4-1];
        prod_p = {{HUE_W{1'b0}}, h4.mx} * {{HUE_W{1'b0}}, FULL_SCALE - h4.sat};
        h4.p   = prod_p[2*HUE_W-1:HUE_W];
        remt   = HALF_SCALE - h4.remh;
        prod_q = {{HUE_W{1'b0}}, h4.sat_half} * {{HUE_W{1'b0}}, h4.remh};
        prod_t = {{HUE_W{1'b0}}, h4.sat_half} * {{HUE_W{1'b0}}, remt};
        h4.prodq = prod_q[HUE_W+13:14];
        h4.prodt = prod_t[HUE_W+13:14];
        stage_next[ST_H4] = h4;

        h5 = stage_reg[ST_H5-1];
        scl_q = {{HUE_W{1'b0}}, h5.mx} * {{HUE_W{1'b0}}, FULL_SCALE - h5.prodq};
        scl_t = {{HUE_W{1'b0}}, h5.mx} * {{HUE_W{1'b0}}, FULL_SCALE - h5.prodt};
        h5.q  = scl_q[2*HUE_W-1:HUE_W];
        h5.t  = scl_t[2*HUE_W-1:HUE_W];
        stage_next[ST_H5] = h5;
    end

    // channel pick by hextant, top three bits of each channel back in place
    always_comb
    begin : pack_calc
        logic [HUE_W-1:0] ro;
        logic [HUE_W-1:0] go;
        logic [HUE_W-1:0] bo;
        pht_item_t        last;

        last = stage_reg[NS-1];
        case (last.hext)
            HEXT_1:
            begin
                ro = last.q;  go = last.mx; bo = last.p;
            end
            HEXT_2:
            begin
                ro = last.p;  go = last.mx; bo = last.t;
            end
            HEXT_3:
            begin
                ro = last.p;  go = last.q;  bo = last.mx;
            end
            HEXT_4:
            begin
                ro = last.t;  go = last.p;  bo = last.mx;
            end
            HEXT_5:
            begin
                ro = last.mx; go = last.p;  bo = last.q;
            end
            default:
            begin
                // first hextant, and the sliver at the top of the circle
                ro = last.mx; go = last.t;  bo = last.p;
            end
        endcase

        if (last.bypass)
        begin
            out_color_next = last.word;
        end
        else
        begin
            out_color_next = {bo[HUE_W-1:HUE_W-3], 1'b0, go[HUE_W-1:HUE_W-3], 1'b0,
                              ro[HUE_W-1:HUE_W-3], 1'b0};
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (stage_load[0])
            begin
                valid_reg[0] <= request.valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (stage_load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (out_load)
            begin
                out_valid_reg <= valid_reg[NS-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (stage_load[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
        if (out_load)
        begin
            out_color_reg <= out_color_next;
        end
    end

endmodule

FILE: hw/rtl/pht_div_step.sv
`timescale 1ns / 1ps

module pht_div_step (
    input  logic [pht_pkg::HUE_W:0]   rem,
    input  logic [pht_pkg::HUE_W-1:0] den,
    input  logic [pht_pkg::HUE_W-1:0] quo,
    output logic [pht_pkg::HUE_W:0]   rem_next,
    output logic [pht_pkg::HUE_W-1:0] quo_next
);
    import pht_pkg::*;

    logic [HUE_W:0] shifted;
    logic           fits;

    // remainder stays below the divisor, so one shifted bit is enough headroom
    assign shifted  = {rem[HUE_W-1:0], 1'b0};
    assign fits     = shifted >= {1'b0, den};
    assign rem_next = fits ? (shifted - {1'b0, den}) : shifted;
    assign quo_next = {quo[HUE_W-2:0], fits};

endmodule

FILE: hw/rtl/pht_checker.sv
`timescale 1ns / 1ps

module pht_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [pht_pkg::COLOR_W-1:0]  color_out
);
    import pht_pkg::*;

    // a held result keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(color_out))
        else $error("result changed while stalled");

    // input back-pressure only comes from a stalled full output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // nothing leaves while in reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // an empty pipe cannot produce a result in the next cycle after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind palette_hue_rotator pht_checker u_pht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .color_out (response.color_out)
);
